FILE: hw/rtl/double_ended_queue_unit_defines.svh
// Assertion macros for the double-ended queue unit.
// Needs clk and rst_n in scope at the point of use.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue unit.
// No dependencies.
`default_nettype none

package deq_pkg;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_DUMP       = 3'd4;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_ELEM  = 2'd3;

  localparam int DATA_W = 32;

endpackage

`default_nettype wire

FILE: hw/rtl/deq_mem.sv
// Element store: one write port, one read port, registered read data.
// Uses deq_pkg for the data width.
`default_nettype none

module deq_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [AW-1:0]                   wr_addr,
  input  wire logic signed [deq_pkg::DATA_W-1:0] wr_data,
  input  wire logic                            rd_en,
  input  wire logic [AW-1:0]                   rd_addr,
  output logic signed [deq_pkg::DATA_W-1:0]    rd_data
);

  logic signed [deq_pkg::DATA_W-1:0] store_r [DEPTH];
  logic signed [deq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/deq_ctrl.sv
// Command sequencer: ring pointers, dump streaming and output register.
// Uses deq_pkg and the assertion macros header; drives deq_mem.
`default_nettype none

`include "double_ended_queue_unit_defines.svh"

module deq_ctrl #(
  parameter int CAPACITY = 32,
  parameter int AW       = 5,
  parameter int CW       = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [2:0]                        in_command,
  input  wire logic signed [deq_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_status,
  output logic signed [deq_pkg::DATA_W-1:0]      out_data,
  output logic                                   out_last,
  output logic                                   mem_we,
  output logic [AW-1:0]                          mem_waddr,
  output logic signed [deq_pkg::DATA_W-1:0]      mem_wdata,
  output logic                                   mem_re,
  output logic [AW-1:0]                          mem_raddr,
  input  wire logic signed [deq_pkg::DATA_W-1:0] mem_rdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;
  localparam int   SW      = CW + 1;
  localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [AW-1:0] TOP_A  = AW'(CAPACITY - 1);

  logic          state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] iss_cnt_r, iss_cnt_nxt;
  logic [CW-1:0] mv_cnt_r, mv_cnt_nxt;
  logic          pend_r, pend_nxt;

  logic                              out_valid_r;
  deq_pkg::status_t                  out_status_r;
  logic signed [deq_pkg::DATA_W-1:0] out_data_r;
  logic                              out_last_r;

  logic                              acc, out_free, move, more, is_full, is_empty;
  logic                              load, ld_last, dump_end;
  deq_pkg::status_t                  ld_status;
  logic signed [deq_pkg::DATA_W-1:0] ld_data;
  logic [CW-1:0]                     ring_off;
  logic [SW-1:0]                     ring_sum;
  logic [AW-1:0]                     ring_addr, front_dec, front_inc;

  assign is_full  = (count_r == CAP_C);
  assign is_empty = (count_r == '0);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign move     = pend_r && out_free;
  assign more     = (iss_cnt_r != count_r);
  assign dump_end = ((mv_cnt_r + CW'(1)) == count_r);

  // one shared ring adder: back slot when idle, read slot during a dump
  assign ring_off  = (state_r == ST_DUMP) ? iss_cnt_r : count_r;
  assign ring_sum  = SW'(front_r) + SW'(ring_off);
  assign ring_addr = (ring_sum >= CAP_S) ? AW'(ring_sum - CAP_S) : AW'(ring_sum);
  assign front_dec = (front_r == '0) ? TOP_A : front_r - AW'(1);
  assign front_inc = (front_r == TOP_A) ? '0 : front_r + AW'(1);

  assign mem_re    = (state_r == ST_DUMP) && more && (!pend_r || move);
  assign mem_raddr = ring_addr;
  assign mem_wdata = in_value;

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    iss_cnt_nxt = iss_cnt_r;
    mv_cnt_nxt  = mv_cnt_r;
    load        = 1'b0;
    ld_status   = deq_pkg::ST_DONE;
    ld_data     = '0;
    ld_last     = 1'b1;
    mem_we      = 1'b0;
    mem_waddr   = ring_addr;

    if (acc) begin
      case (in_command)
        deq_pkg::CMD_PUSH_FRONT: begin
          load = 1'b1;
          if (is_full) begin
            ld_status = deq_pkg::ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        deq_pkg::CMD_PUSH_BACK: begin
          load = 1'b1;
          if (is_full) begin
            ld_status = deq_pkg::ST_FULL;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          load = 1'b1;
          if (is_empty) begin
            ld_status = deq_pkg::ST_EMPTY;
          end else begin
            front_nxt = front_inc;
            count_nxt = count_r - CW'(1);
          end
        end
        deq_pkg::CMD_POP_BACK: begin
          load = 1'b1;
          if (is_empty) begin
            ld_status = deq_pkg::ST_EMPTY;
          end else begin
            count_nxt = count_r - CW'(1);
          end
        end
        deq_pkg::CMD_DUMP: begin
          if (is_empty) begin
            load      = 1'b1;
            ld_status = deq_pkg::ST_EMPTY;
          end else begin
            state_nxt   = ST_DUMP;
            iss_cnt_nxt = '0;
            mv_cnt_nxt  = '0;
          end
        end
        default: begin
        end
      endcase
    end

    if (state_r == ST_DUMP) begin
      if (mem_re) begin
        iss_cnt_nxt = iss_cnt_r + CW'(1);
      end
      if (move) begin
        load       = 1'b1;
        ld_status  = deq_pkg::ST_ELEM;
        ld_data    = mem_rdata;
        ld_last    = dump_end;
        mv_cnt_nxt = mv_cnt_r + CW'(1);
        if (dump_end) begin
          state_nxt = ST_IDLE;
        end
      end
    end
  end

  // read data sits in the memory output register until moved
  always_comb begin
    pend_nxt = pend_r;
    if (mem_re) begin
      pend_nxt = 1'b1;
    end else if (move) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      iss_cnt_r   <= '0;
      mv_cnt_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      count_r   <= count_nxt;
      iss_cnt_r <= iss_cnt_nxt;
      mv_cnt_r  <= mv_cnt_nxt;
      pend_r    <= pend_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= ld_status;
      out_data_r   <= ld_data;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

  `DEQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CAP_C, "element count above capacity")
  `DEQ_ASSERT_IMP(a_no_wr_in_dump, state_r == ST_DUMP, !mem_we, "store written during dump")
  `DEQ_ASSERT_IMP(a_mv_le_iss, state_r == ST_DUMP, mv_cnt_r <= iss_cnt_r,
                  "more beats moved than reads issued")
  `DEQ_ASSERT_NXT(a_pend_held, pend_r && !move, pend_r, "pending read data dropped")

endmodule

`default_nettype wire

FILE: hw/rtl/double_ended_queue_unit.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
// Uses deq_pkg; instantiates deq_ctrl and deq_mem.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_command[2:0], in_value[31:0] signed
//   out_     out  out_valid/out_ready  out_status[1:0], out_data[31:0] signed, out_last
//
// Push and pop load their status beat into the output register at the accepting
// edge, so these commands run at one per cycle while the output is not stalled.
// A dump reads the store front to back through the one read port and moves each
// word on to the output register, one beat per cycle while the output is free.
// Reset is synchronous, active low; it clears pointers, counts and flags, and the
// store needs no clearing pass. Unused command codes are taken without a beat.
// A stalled output holds the dump: no read issues while read data waits.
`default_nettype none

module double_ended_queue_unit #(
  parameter int CAPACITY = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // command channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [2:0]                        in_command,
  input  wire logic signed [deq_pkg::DATA_W-1:0] in_value,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_status,
  output logic signed [deq_pkg::DATA_W-1:0]      out_data,
  output logic                                   out_last
);

  // ring slot index and element count widths (count must reach CAPACITY)
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic signed [deq_pkg::DATA_W-1:0] mem_wdata;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;
  logic signed [deq_pkg::DATA_W-1:0] mem_rdata;

  // sequencer: front pointer, count, dump counters and the output beat register
  deq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // ring store: pushes write, dumps read; never both in one cycle
  deq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue_unit: a directed command table, then
// phased random traffic, with every result beat compared against a shadow deque.
// Depends on deq_pkg and the unit's RTL only.

module testbench;

  localparam int DEPTH        = 32;         // matches the unit's CAPACITY
  localparam int RANDOM_ITEMS = 400;        // real commands in the random part
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int QUIET_CYCLES = 40;         // idle time at the end, to catch stray beats
  localparam int MAX_REPORTS  = 10;

  // Command codes the unit must swallow without a beat
  localparam deq_pkg::cmd_t CMD_UNUSED_LO  = 3'd5;
  localparam deq_pkg::cmd_t CMD_UNUSED_MID = 3'd6;
  localparam deq_pkg::cmd_t CMD_UNUSED_HI  = 3'd7;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;
  typedef enum logic [1:0] {SINK_OPEN, SINK_LIGHT, SINK_PULSED, SINK_COIN} sink_mode_t;

  typedef struct packed {
    deq_pkg::status_t                  status;
    logic signed [deq_pkg::DATA_W-1:0] data;
    logic                              last;
  } beat_t;

  // One row of the directed table. Where typed is set, the status is written in
  // by hand (single-beat answers only); otherwise the shadow deque decides.
  typedef struct {
    deq_pkg::cmd_t              cmd;
    logic [deq_pkg::DATA_W-1:0] value;
    bit                         typed;
    deq_pkg::status_t           status;
  } stim_row_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_valid   = 1'b0;
  logic                              in_ready;
  logic [2:0]                        in_command = deq_pkg::CMD_PUSH_FRONT;
  logic signed [deq_pkg::DATA_W-1:0] in_value   = '0;
  logic                              out_valid;
  logic                              out_ready  = 1'b0;
  logic [1:0]                        out_status;
  logic signed [deq_pkg::DATA_W-1:0] out_data;
  logic                              out_last;

  // Travels with the command beat so the monitor knows how to build the expectation
  bit               row_typed  = 1'b0;
  deq_pkg::status_t row_status = deq_pkg::ST_DONE;

  logic signed [deq_pkg::DATA_W-1:0] shadow_words [$];  // front of deque at index 0
  beat_t                             fresh_beats [$];   // beats caused by the latest command
  beat_t                             replies_due [$];   // beats still owed by the unit

  int         errors        = 0;
  int         beats_checked = 0;
  int         full_seen     = 0;
  int         empty_seen    = 0;
  int         elems_seen    = 0;
  int         cycle_count   = 0;
  int         burst_left    = 0;
  int         random_sent   = 0;
  sink_mode_t sink_mode     = SINK_OPEN;

  // Directed part: empty answers straight out of reset, swallowed codes, the
  // extreme words pushed at both ends, dumps between pops, back to empty.
  stim_row_t directed_rows [23] = '{
    '{deq_pkg::CMD_POP_FRONT,  32'h1234_5678, 1'b1, deq_pkg::ST_EMPTY},
    '{deq_pkg::CMD_POP_BACK,   32'hFFFF_FFFF, 1'b1, deq_pkg::ST_EMPTY},
    '{deq_pkg::CMD_DUMP,       32'h8000_0000, 1'b1, deq_pkg::ST_EMPTY},
    '{CMD_UNUSED_LO,           32'hFFFF_FFFF, 1'b0, deq_pkg::ST_DONE},
    '{CMD_UNUSED_MID,          32'h0000_0000, 1'b0, deq_pkg::ST_DONE},
    '{CMD_UNUSED_HI,           32'h5555_5555, 1'b0, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_PUSH_FRONT, 32'h0000_0000, 1'b1, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_DUMP,       32'hDEAD_BEEF, 1'b0, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_POP_FRONT,  32'h0000_0001, 1'b1, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_DUMP,       32'h0000_0000, 1'b0, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b1, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_DUMP,       32'h0000_0000, 1'b0, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, deq_pkg::ST_DONE},
    '{CMD_UNUSED_HI,           32'h0000_0000, 1'b0, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_DUMP,       32'h0000_0000, 1'b0, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b1, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b1, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b1, deq_pkg::ST_DONE},
    '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b1, deq_pkg::ST_EMPTY},
    '{deq_pkg::CMD_DUMP,       32'h0000_0000, 1'b1, deq_pkg::ST_EMPTY}
  };

  double_ended_queue_unit #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_command(in_command),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_data  (out_data),
    .out_last  (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow deque: applies one command and leaves the beats it causes in fresh_beats.
  // Capacity is the only bound; data is zero on every beat but dump elements.
  task automatic shadow_deque_step(input deq_pkg::cmd_t cmd,
                                   input logic signed [deq_pkg::DATA_W-1:0] word);
    fresh_beats.delete();
    case (cmd)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
        if (shadow_words.size() >= DEPTH) begin
          fresh_beats.push_back('{deq_pkg::ST_FULL, '0, 1'b1});  // dropped, deque untouched
        end else begin
          if (cmd == deq_pkg::CMD_PUSH_FRONT) shadow_words.push_front(word);
          else shadow_words.push_back(word);
          fresh_beats.push_back('{deq_pkg::ST_DONE, '0, 1'b1});
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
        if (shadow_words.size() == 0) begin
          fresh_beats.push_back('{deq_pkg::ST_EMPTY, '0, 1'b1});
        end else begin
          // popped word is simply discarded
          if (cmd == deq_pkg::CMD_POP_FRONT) shadow_words.delete(0);
          else shadow_words.delete(shadow_words.size() - 1);
          fresh_beats.push_back('{deq_pkg::ST_DONE, '0, 1'b1});
        end
      end
      deq_pkg::CMD_DUMP: begin
        if (shadow_words.size() == 0) begin
          fresh_beats.push_back('{deq_pkg::ST_EMPTY, '0, 1'b1});
        end else begin
          // front to back, last flag only on the back element
          foreach (shadow_words[i])
            fresh_beats.push_back('{deq_pkg::ST_ELEM, shadow_words[i],
                                    i == shadow_words.size() - 1});
        end
      end
      default: ;  // unused codes: no beat, no change
    endcase
  endtask

  task automatic log_fault(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] %s", $time, what);
  endtask

  // Monitor: both handshakes are sampled at the edge where they complete. The
  // command side runs first so a same-edge answer would still find its expectation.
  always @(posedge clk) begin
    beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        shadow_deque_step(in_command, in_value);
        if (row_typed) replies_due.push_back('{row_status, '0, 1'b1});
        else foreach (fresh_beats[i]) replies_due.push_back(fresh_beats[i]);
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          log_fault($sformatf("unexpected beat: status %0d data %0d last %0b",
                              out_status, out_data, out_last));
        end else begin
          want = replies_due.pop_front();
          beats_checked++;
          case (want.status)
            deq_pkg::ST_FULL:  full_seen++;
            deq_pkg::ST_EMPTY: empty_seen++;
            deq_pkg::ST_ELEM:  elems_seen++;
            default:           ;
          endcase
          if (out_status !== want.status || out_data !== want.data || out_last !== want.last)
            log_fault($sformatf({"mismatch: expected status %0d data %0d last %0b, ",
                                 "got status %0d data %0d last %0b"},
                                want.status, want.data, want.last,
                                out_status, out_data, out_last));
        end
      end
    end
  end

  // Receiver: a stall mode picked at random on a schedule set by the cycle counter;
  // open, light stalls, ready on a periodic pulse, or a coin toss.
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) sink_mode <= sink_mode_t'($urandom_range(0, 3));
    case (sink_mode)
      SINK_OPEN:   out_ready <= 1'b1;
      SINK_LIGHT:  out_ready <= ($urandom_range(0, 3) != 0);
      SINK_PULSED: out_ready <= (cycle_count % 8 == 0);
      default:     out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still owed", cycle_count,
               replies_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sender: bursts of back-to-back beats (sometimes long ones) split by short
  // gaps. Called at a rising edge; returns at the edge where the beat is taken.
  task automatic offer_command(input deq_pkg::cmd_t cmd,
                               input logic [deq_pkg::DATA_W-1:0] word,
                               input bit typed, input deq_pkg::status_t status);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 48) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= word;
    row_typed  <= typed;
    row_status <= status;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off until the unit owes nothing. It waits on the clock before checking, so the monitor has
  // booked the beat that was accepted at the edge we were called on.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // Words lean on the extremes, the rest uniform over the full range
  function automatic logic [deq_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Fill phases run the deque into full and past it, drain phases into empty
  // and past it; mixed phases are uniform and carry the odd unused code as noise.
  function automatic deq_pkg::cmd_t pick_command(input phase_t phase);
    int roll;
    roll = $urandom_range(0, 99);
    case (phase)
      PH_FILL: begin
        if (roll < 44) return deq_pkg::CMD_PUSH_FRONT;
        if (roll < 88) return deq_pkg::CMD_PUSH_BACK;
        if (roll < 91) return deq_pkg::CMD_POP_FRONT;
        if (roll < 94) return deq_pkg::CMD_POP_BACK;
        return deq_pkg::CMD_DUMP;
      end
      PH_DRAIN: begin
        if (roll < 44) return deq_pkg::CMD_POP_FRONT;
        if (roll < 88) return deq_pkg::CMD_POP_BACK;
        if (roll < 91) return deq_pkg::CMD_PUSH_FRONT;
        if (roll < 94) return deq_pkg::CMD_PUSH_BACK;
        return deq_pkg::CMD_DUMP;
      end
      default: begin
        if (roll < 3) return deq_pkg::cmd_t'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        return deq_pkg::cmd_t'($urandom_range(deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_DUMP));
      end
    endcase
  endfunction

  initial begin
    phase_t        phase;
    int            span;
    deq_pkg::cmd_t cmd;
    bit            paused_once;
    paused_once = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      offer_command(directed_rows[r].cmd, directed_rows[r].value,
                    directed_rows[r].typed, directed_rows[r].status);
    settle();

    // Random part opens with a fill so the full case turns up early
    phase = PH_FILL;
    while (random_sent < RANDOM_ITEMS) begin
      span = (phase == PH_MIX) ? $urandom_range(24, 56) : $urandom_range(40, 56);
      for (int k = 0; k < span && random_sent < RANDOM_ITEMS; k++) begin
        cmd = pick_command(phase);
        if (cmd <= deq_pkg::CMD_DUMP) random_sent++;  // swallowed codes don't count
        offer_command(cmd, pick_word(), 1'b0, deq_pkg::ST_DONE);
      end
      // First phase boundary always drains; later ones now and then
      if (!paused_once || $urandom_range(0, 2) == 0) begin
        settle();
        paused_once = 1'b1;
      end
      phase = phase_t'($urandom_range(0, 2));
    end

    settle();
    repeat (QUIET_CYCLES) @(posedge clk);

    $display("Ran %0d directed and %0d random commands; %0d result beats checked",
             $size(directed_rows), random_sent, beats_checked);
    $display("  of which %0d full refusals, %0d empty answers, %0d dump elements; %0d faults",
             full_seen, empty_seen, elems_seen, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: double_ended_queue_unit.f
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/deq_mem.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue_unit.sv
bench/testbench.sv
